>>> sv/additive_lagged_fibonacci_rng_core_assert.svh
// Assertion macros for the additive lagged-Fibonacci generator.
`ifndef ADDITIVE_LAGGED_FIBONACCI_RNG_CORE_ASSERT_SVH
`define ADDITIVE_LAGGED_FIBONACCI_RNG_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define ALFR_ASSERT_NOW(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("alfr: same-cycle check failed");
// next-cycle implication
`define ALFR_ASSERT_NEXT(lbl, clock, reset, ante, cons) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("alfr: next-cycle check failed");
`else
`define ALFR_ASSERT_NOW(lbl, clock, reset, ante, cons)
`define ALFR_ASSERT_NEXT(lbl, clock, reset, ante, cons)
`endif
`endif

>>> sv/alfr_pkg.sv
package alfr_pkg;

  localparam int TABLE_DEGREE   = 31;
  localparam int TAP_SEPARATION = 3;
  localparam int IDX_W          = $clog2(TABLE_DEGREE);
  localparam int WARMUP_STEPS   = TABLE_DEGREE * 10;
  localparam int WARM_W         = $clog2(WARMUP_STEPS);

  localparam logic [31:0] SCHRAGE_Q  = 32'd127773;
  localparam logic [31:0] SCHRAGE_A  = 32'd16807;
  localparam logic [31:0] SCHRAGE_R  = 32'd2836;
  localparam logic [31:0] PM_MODULUS = 32'd2147483647;

  // floor(2^48 / Q): quotient estimate is exact or one low for 32-bit dividends
  localparam int          RECIP_SHIFT   = 48;
  localparam logic [31:0] SCHRAGE_RECIP = 32'((64'd1 << RECIP_SHIFT) / 64'd127773);
  localparam int          HI_W          = 15;  // |w| / Q <= 16807
  localparam int          LO_W          = 17;  // remainder < Q after correction

  localparam logic CMD_RESEED = 1'b0;
  localparam logic CMD_DRAW   = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [IDX_W:0]    idx_ext_t;
  typedef logic [WARM_W-1:0] warm_t;
  typedef logic [31:0]       word_t;

  function automatic idx_t idx_inc(idx_t i);
    return (i == idx_t'(TABLE_DEGREE - 1)) ? '0 : i + 1'b1;
  endfunction

  // front pointer that belongs to a given rear pointer
  function automatic idx_t lag_index(idx_t r);
    idx_ext_t s;
    s = {1'b0, r} + idx_ext_t'(TAP_SEPARATION % TABLE_DEGREE);
    if (s >= idx_ext_t'(TABLE_DEGREE)) s = s - idx_ext_t'(TABLE_DEGREE);
    return s[IDX_W-1:0];
  endfunction

  function automatic word_t abs_word(word_t v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

>>> sv/additive_lagged_fibonacci_rng_core.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------
// request   | cmd_valid / cmd_stall  | cmd (1b), seed_value (32b)
// result    | rand_valid / rand_stall| random_value (31b), one per draw
//
// Draws: one request per cycle while cmd_stall is low; rand_valid rises once the
// registered RAM read has passed the add/write-back stage (with forwarding on a same-entry hit).
// Reseed: cmd_stall stays high for 1 seed write, 30 entries through the Schrage
// DIV/QEST/CORR/MUL/SUM divide/multiply sequencer and 310 warm-up steps on the RAM port.
// Reset: pointers go to 3/0 and the table reads as zero until first reseed.
// rand_stall holds the result register; one more draw may be in flight.
`include "additive_lagged_fibonacci_rng_core_assert.svh"

module additive_lagged_fibonacci_rng_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic        cmd,
  input  logic [31:0] seed_value,
  output logic        rand_valid,
  input  logic        rand_stall,
  output logic [30:0] random_value
);
  import alfr_pkg::*;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;  // serving draws
  localparam logic [2:0] ST_SEED = 3'd1;  // write seed into entry 0
  localparam logic [2:0] ST_DIV  = 3'd2;  // |w| * reciprocal
  localparam logic [2:0] ST_QEST = 3'd3;  // quotient estimate times Q
  localparam logic [2:0] ST_CORR = 3'd4;  // remainder and quotient fix-up
  localparam logic [2:0] ST_MUL  = 3'd5;  // A*lo and R*hi
  localparam logic [2:0] ST_SUM  = 3'd6;  // combine, fold modulus, write entry
  localparam logic [2:0] ST_WARM = 3'd7;  // discarded steps

  logic [2:0] state;
  logic       seeded;        // table holds real data
  idx_t       front_index;
  idx_t       rear_index;
  idx_t       fill_idx;
  warm_t      warm_cnt;

  // Schrage datapath
  word_t             seed_reg;
  logic              w_neg;
  word_t             abs_w;
  logic [63:0]       prod;
  logic [HI_W-1:0]   quot;
  word_t             qd;
  logic [LO_W-1:0]   lo;
  word_t             pa;
  word_t             pb;
  word_t             rem;
  logic signed [32:0] diff;
  logic signed [32:0] diff_adj;
  word_t             fill_val;

  // table RAM
  word_t mem [TABLE_DEGREE];
  logic  mem_we;
  idx_t  mem_waddr;
  word_t mem_wdata;
  word_t rd_f_data;
  word_t rd_r_data;

  // add/write-back stage
  logic  s1_valid;
  logic  s1_emit;      // draw (result) vs warm-up step
  idx_t  s1_addr;
  logic  fwd_f;
  logic  fwd_r;
  word_t fwd_data;
  word_t s1_front;
  word_t s1_rear;
  word_t s1_sum;
  logic  s1_go;
  logic  s1_free;

  logic  req_accept;
  logic  issue;

  // ---------------- handshake and step issue ----------------
  assign s1_go      = s1_valid && (!s1_emit || !rand_valid || !rand_stall);
  assign s1_free    = !s1_valid || s1_go;
  assign cmd_stall  = (state != ST_IDLE) || !s1_free;
  assign req_accept = cmd_valid && !cmd_stall;
  assign issue      = (req_accept && (cmd == CMD_DRAW)) ||
                      ((state == ST_WARM) && s1_free);

  // ---------------- add/write-back stage ----------------
  always_comb begin
    s1_front = fwd_f ? fwd_data : rd_f_data;
    s1_rear  = fwd_r ? fwd_data : rd_r_data;
    s1_sum   = seeded ? (s1_front + s1_rear) : '0;
  end

  // ---------------- Schrage combine ----------------
  always_comb begin
    rem = abs_w - qd;
    if (w_neg) begin
      diff = $signed({1'b0, pb}) - $signed({1'b0, pa});
    end else begin
      diff = $signed({1'b0, pa}) - $signed({1'b0, pb});
    end
    diff_adj = (diff < 0) ? (diff + $signed({1'b0, PM_MODULUS})) : diff;
    fill_val = word_t'(diff_adj[31:0]);
  end

  // ---------------- write port mux ----------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_addr;
    mem_wdata = s1_sum;
    if (s1_go) begin
      mem_we = 1'b1;
    end else if (state == ST_SEED) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = seed_reg;
    end else if (state == ST_SUM) begin
      mem_we    = 1'b1;
      mem_waddr = fill_idx;
      mem_wdata = fill_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_f_data <= mem[front_index];
      rd_r_data <= mem[rear_index];
      fwd_f     <= s1_go && (s1_addr == front_index);
      fwd_r     <= s1_go && (s1_addr == rear_index);
      fwd_data  <= s1_sum;
      s1_addr   <= front_index;
      s1_emit   <= (state == ST_IDLE);
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      seeded      <= 1'b0;
      front_index <= idx_t'(TAP_SEPARATION % TABLE_DEGREE);
      rear_index  <= '0;
      s1_valid    <= 1'b0;
      rand_valid  <= 1'b0;
      fill_idx    <= '0;
      warm_cnt    <= '0;
    end else begin
      if (issue) begin
        s1_valid    <= 1'b1;
        front_index <= idx_inc(front_index);
        rear_index  <= idx_inc(rear_index);
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_go && s1_emit) begin
        rand_valid <= 1'b1;
      end else if (!rand_stall) begin
        rand_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req_accept && (cmd == CMD_RESEED)) begin
            state       <= ST_SEED;
            front_index <= idx_t'(TAP_SEPARATION % TABLE_DEGREE);
            rear_index  <= '0;
          end
        end
        ST_SEED: begin
          seeded   <= 1'b1;
          fill_idx <= idx_t'(1);
          state    <= ST_DIV;
        end
        ST_DIV:  state <= ST_QEST;
        ST_QEST: state <= ST_CORR;
        ST_CORR: state <= ST_MUL;
        ST_MUL:  state <= ST_SUM;
        ST_SUM: begin
          if (fill_idx == idx_t'(TABLE_DEGREE - 1)) begin
            warm_cnt <= '0;
            state    <= ST_WARM;
          end else begin
            fill_idx <= fill_idx + 1'b1;
            state    <= ST_DIV;
          end
        end
        ST_WARM: begin
          if (issue) begin
            warm_cnt <= warm_cnt + 1'b1;
            if (warm_cnt == warm_t'(WARMUP_STEPS - 1)) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (req_accept && (cmd == CMD_RESEED)) begin
      seed_reg <= (seed_value == '0) ? 32'd1 : seed_value;
    end
    unique case (state)
      ST_SEED: begin
        w_neg <= seed_reg[31];
        abs_w <= abs_word(seed_reg);
      end
      ST_DIV: begin
        prod <= {32'd0, abs_w} * {32'd0, SCHRAGE_RECIP};
      end
      ST_QEST: begin
        quot <= prod[RECIP_SHIFT +: HI_W];
        qd   <= word_t'({{(32 - HI_W){1'b0}}, prod[RECIP_SHIFT +: HI_W]} * SCHRAGE_Q);
      end
      ST_CORR: begin
        if (rem >= SCHRAGE_Q) begin
          quot <= quot + 1'b1;
          lo   <= LO_W'(rem - SCHRAGE_Q);
        end else begin
          lo   <= LO_W'(rem);
        end
      end
      ST_MUL: begin
        pa <= word_t'({{(32 - LO_W){1'b0}}, lo} * SCHRAGE_A);
        pb <= word_t'({{(32 - HI_W){1'b0}}, quot} * SCHRAGE_R);
      end
      ST_SUM: begin
        w_neg <= fill_val[31];
        abs_w <= abs_word(fill_val);
      end
      default: ;
    endcase
    if (s1_go && s1_emit) begin
      random_value <= s1_sum[31:1];
    end
  end

  // ---------------- checks ----------------
  `ALFR_ASSERT_NOW(a_lag_kept, clk, rst, 1'b1, front_index == lag_index(rear_index))
  `ALFR_ASSERT_NOW(a_no_overrun, clk, rst, s1_valid && s1_emit && rand_valid && rand_stall, cmd_stall)
  `ALFR_ASSERT_NEXT(a_reseed_starts, clk, rst, req_accept && (cmd == CMD_RESEED), state == ST_SEED)
  `ALFR_ASSERT_NOW(a_fill_in_range, clk, rst, state == ST_SUM, fill_val < PM_MODULUS)
  `ALFR_ASSERT_NOW(a_result_source, clk, rst, $rose(rand_valid), $past(s1_valid && s1_emit))

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import alfr_pkg::*;

  // One request: opcode plus seed word (seed is ignored on a draw).
  typedef struct {
    logic        op;
    logic [31:0] seed;
  } rng_req_t;

  localparam int RANDOM_REQS = 1550;
  localparam int CALM_TAIL   = 150;  // last requests are sent with no idling
  localparam int LONG_HOLD   = 200;  // one long result hold-off, in cycles
  localparam int HOLD_AFTER  = 400;  // draws accepted before the long hold-off
  localparam int DRAIN_WAIT  = 500;  // covers a reseed still running at the end

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic        cmd = CMD_DRAW;
  logic [31:0] seed_value = '0;
  logic        rand_valid;
  logic        rand_stall = 1'b0;
  logic [30:0] random_value;

  additive_lagged_fibonacci_rng_core dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .seed_value   (seed_value),
    .rand_valid   (rand_valid),
    .rand_stall   (rand_stall),
    .random_value (random_value)
  );

  always #10 clk = ~clk;

  // Requests waiting to be offered, and draw results still to come back.
  rng_req_t    req_queue[$];
  logic [30:0] draw_expect[$];

  int err_cnt    = 0;
  int req_total  = 0;
  int req_taken_cnt = 0;
  int draw_taken = 0;
  bit req_taken  = 1'b0;  // request handshake seen at the last rising edge

  // ---------------------------------------------------------------------
  // Shadow generator: lagged-Fibonacci table with front/rear taps.
  // ---------------------------------------------------------------------
  logic [31:0] fib_words [TABLE_DEGREE];
  int unsigned front_ptr;
  int unsigned rear_ptr;

  function automatic void fib_clear();
    for (int i = 0; i < TABLE_DEGREE; i++) fib_words[i] = '0;
    front_ptr = TAP_SEPARATION % TABLE_DEGREE;
    rear_ptr  = 0;
  endfunction

  // x[front] += x[rear], both taps advance; returns the new front word.
  function automatic logic [31:0] fib_advance();
    logic [31:0] sum;
    sum = fib_words[front_ptr] + fib_words[rear_ptr];
    fib_words[front_ptr] = sum;
    front_ptr = (front_ptr == TABLE_DEGREE - 1) ? 0 : front_ptr + 1;
    rear_ptr  = (rear_ptr == TABLE_DEGREE - 1) ? 0 : rear_ptr + 1;
    return sum;
  endfunction

  // Park-Miller fill via Schrage, then warm-up steps thrown away.
  function automatic void fib_reseed(logic [31:0] seed);
    logic [31:0] s;
    longint      w;
    longint      hi;
    longint      lo;
    longint      q_l;
    longint      a_l;
    longint      r_l;
    longint      m_l;
    logic [31:0] junk;
    q_l = longint'(SCHRAGE_Q);
    a_l = longint'(SCHRAGE_A);
    r_l = longint'(SCHRAGE_R);
    m_l = longint'(PM_MODULUS);
    s = (seed == '0) ? 32'd1 : seed;
    w = longint'($signed(s));
    fib_words[0] = s;
    for (int i = 1; i < TABLE_DEGREE; i++) begin
      // SV division truncates toward zero, remainder follows the dividend
      hi = w / q_l;
      lo = w % q_l;
      w  = a_l * lo - r_l * hi;
      if (w < 0) w = w + m_l;
      fib_words[i] = w[31:0];
    end
    front_ptr = TAP_SEPARATION % TABLE_DEGREE;
    rear_ptr  = 0;
    for (int i = 0; i < WARMUP_STEPS; i++) junk = fib_advance();
  endfunction

  // Seeds biased toward the awkward corners: zero, tiny, negative, near -1.
  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'($urandom_range(1, 255));
      2: return {1'b1, 31'($urandom)};
      3: return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic void push_req(logic op, logic [31:0] seed);
    rng_req_t r;
    r.op   = op;
    r.seed = seed;
    req_queue.push_back(r);
    req_total++;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver: changes inputs on the falling edge. A new request is
  // loaded only once the current one was taken (or nothing is offered).
  // Random idle bursts, none near the end of the run.
  // ---------------------------------------------------------------------
  int send_gap = 0;

  always @(negedge clk) begin
    rng_req_t nxt;
    logic     nv;
    if (!rst && (!cmd_valid || req_taken)) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (req_queue.size() > 0) begin
        nxt = req_queue.pop_front();
        nv  = 1'b1;
        cmd        <= nxt.op;
        seed_value <= nxt.seed;
        if (req_queue.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
          send_gap = $urandom_range(1, 7);
      end
      cmd_valid <= nv;
    end
  end

  // ---------------------------------------------------------------------
  // Result receiver: random stall bursts, plus one long hold-off while
  // draws keep coming so the pipeline backs up into cmd_stall.
  // ---------------------------------------------------------------------
  int  stall_left = 0;
  bit  long_hold_done = 1'b0;

  always @(negedge clk) begin
    logic st;
    st = 1'b0;
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left--;
        st = 1'b1;
      end else if (!long_hold_done && draw_taken >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD - 1;
        st = 1'b1;
      end else if (req_queue.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        st = 1'b1;
      end
    end
    rand_stall <= st;
  end

  // ---------------------------------------------------------------------
  // Monitor: samples both handshakes on the rising edge. Results are
  // checked first, then the accepted request updates the shadow state.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic [30:0] want;
    req_taken = 1'b0;
    if (!rst) begin
      if (rand_valid && !rand_stall) begin
        if (draw_expect.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, random_value);
          err_cnt++;
        end else begin
          want = draw_expect.pop_front();
          if (random_value !== want) begin
            $display("%0t: random_value mismatch, expected %h, got %h",
                     $time, want, random_value);
            err_cnt++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        req_taken = 1'b1;
        req_taken_cnt++;
        if (cmd == CMD_DRAW) begin
          want = 31'(fib_advance() >> 1);
          draw_expect.push_back(want);
          draw_taken++;
        end else begin
          fib_reseed(seed_value);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------
  initial begin
    fib_clear();

    // draws on the zero table before any seed
    repeat (3) push_req(CMD_DRAW, $urandom);
    // seed zero maps to one
    push_req(CMD_RESEED, 32'd0);
    repeat (2) push_req(CMD_DRAW, $urandom);
    push_req(CMD_RESEED, 32'd1);
    push_req(CMD_DRAW, $urandom);
    // largest positive, most negative, -1 and neighbors
    push_req(CMD_RESEED, 32'h7FFF_FFFF);
    push_req(CMD_DRAW, $urandom);
    push_req(CMD_RESEED, 32'h8000_0000);
    push_req(CMD_DRAW, $urandom);
    push_req(CMD_RESEED, 32'h8000_0001);
    push_req(CMD_DRAW, $urandom);
    push_req(CMD_RESEED, 32'hFFFF_FFFF);
    push_req(CMD_DRAW, 32'hFFFF_FFFF);
    // exact multiples of the Schrage quotient, both signs
    push_req(CMD_RESEED, 32'd127773);
    push_req(CMD_DRAW, 32'h0000_0000);
    push_req(CMD_RESEED, 32'(-127773));
    repeat (3) push_req(CMD_DRAW, $urandom);

    // random part: mostly draws, occasional reseeds
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if ($urandom_range(0, 99) < 3)
        push_req(CMD_RESEED, pick_seed());
      else
        push_req(CMD_DRAW, $urandom);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_taken_cnt < req_total || draw_expect.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (err_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
